@@ design/assert_macros.svh @@
// Assertion macros used by the rotator top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on every clock edge, disabled in reset
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Assert that a condition implies a consequence on the next edge
`define ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error(msg);

`endif

@@ design/aavr_pkg.sv @@
// ----------------------------------------------------------------------------
// aavr_pkg
// Constants, types and helper functions of the axis-angle vector rotator.
// ----------------------------------------------------------------------------
package aavr_pkg;

   localparam int ANGLE_BITS       = 16;
   localparam int SINE_TABLE_DEPTH = 1024;
   localparam int TRIG_FRAC        = 24;
   localparam int AXIS_FRAC        = 14;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   localparam int PHASE_W = ANGLE_BITS + 1;
   localparam int QPH_W   = ANGLE_BITS - 1;
   localparam int IDX_W   = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int ROM_W   = TRIG_FRAC + 1;
   localparam int SN_W    = TRIG_FRAC + 2;
   localparam int AXIS_W  = 16;
   localparam int VEC_W   = 32;
   localparam int R_W     = SN_W + 1;
   localparam int P1_W    = R_W + VEC_W;
   localparam int T_W     = 36;
   localparam int P2_W    = T_W + R_W;
   localparam int REQ_W   = 160;
   localparam int RSP_W   = 96;

   localparam int NUM_STAGES = 7;
   localparam int ST_INDEX   = 0;
   localparam int ST_LOOKUP  = 1;
   localparam int ST_QUAT    = 2;
   localparam int ST_PROD1   = 3;
   localparam int ST_SUM1    = 4;
   localparam int ST_PROD2   = 5;
   localparam int ST_OUT     = 6;

   typedef struct packed {
      logic [NUM_STAGES-1:0] load;
   } pipe_ctrl_type;

   typedef logic [ROM_W-1:0] sin_rom_type [0:SINE_TABLE_DEPTH];

   function automatic logic [ROM_W-1:0] sin_entry(input int k);
      logic [63:0] th;
      logic [63:0] t2;
      logic [63:0] term;
      logic signed [63:0] sum;
      logic [63:0] v;
      th   = (HALF_PI_Q30 * 64'(k)) / SINE_TABLE_DEPTH;
      t2   = (th * th) >> 30;
      term = th;
      sum  = $signed(th);
      term = ((term * t2) >> 30) / 6;   sum = sum - $signed(term);
      term = ((term * t2) >> 30) / 20;  sum = sum + $signed(term);
      term = ((term * t2) >> 30) / 42;  sum = sum - $signed(term);
      term = ((term * t2) >> 30) / 72;  sum = sum + $signed(term);
      term = ((term * t2) >> 30) / 110; sum = sum - $signed(term);
      term = ((term * t2) >> 30) / 156; sum = sum + $signed(term);
      term = ((term * t2) >> 30) / 210; sum = sum - $signed(term);
      term = ((term * t2) >> 30) / 272; sum = sum + $signed(term);
      term = ((term * t2) >> 30) / 342; sum = sum - $signed(term);
      term = ((term * t2) >> 30) / 420; sum = sum + $signed(term);
      term = ((term * t2) >> 30) / 506; sum = sum - $signed(term);
      if (sum < 0) begin
         sum = 0;
      end
      v = ($unsigned(sum) + 64'd32) >> 6;
      if (v > (64'd1 << TRIG_FRAC)) begin
         v = 64'd1 << TRIG_FRAC;
      end
      return v[ROM_W-1:0];
   endfunction

   function automatic sin_rom_type build_rom();
      sin_rom_type rom;
      for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
         rom[k] = sin_entry(k);
      end
      rom[SINE_TABLE_DEPTH] = ROM_W'(64'd1 << TRIG_FRAC);
      return rom;
   endfunction

   localparam sin_rom_type SIN_ROM = build_rom();

   // round to nearest, ties away from zero
   function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                   input int s);
      logic [63:0] mag;
      logic [63:0] r;
      mag = v[63] ? $unsigned(-v) : $unsigned(v);
      r   = (mag + (64'd1 << (s - 1))) >> s;
      return v[63] ? -$signed(r) : $signed(r);
   endfunction

   function automatic logic signed [VEC_W-1:0] sat32(input logic signed [63:0] v);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = 64'sd2147483647;
      lo = -64'sd2147483648;
      if (v > hi) begin
         return VEC_W'(hi);
      end else if (v < lo) begin
         return VEC_W'(lo);
      end
      return VEC_W'(v);
   endfunction

endpackage

@@ design/aavr_quat.sv @@
// ----------------------------------------------------------------------------
// aavr_quat
// Half-angle phase indexing, quarter-wave table lookup and quaternion build.
// ----------------------------------------------------------------------------
module aavr_quat (
   input  logic                                 clock,
   input  aavr_pkg::pipe_ctrl_type              ctrl,
   input  logic [15:0]                          angle,
   input  logic signed [aavr_pkg::AXIS_W-1:0]   axis_x,
   input  logic signed [aavr_pkg::AXIS_W-1:0]   axis_y,
   input  logic signed [aavr_pkg::AXIS_W-1:0]   axis_z,
   input  logic signed [aavr_pkg::VEC_W-1:0]    vec_x,
   input  logic signed [aavr_pkg::VEC_W-1:0]    vec_y,
   input  logic signed [aavr_pkg::VEC_W-1:0]    vec_z,
   output logic signed [aavr_pkg::R_W-1:0]      q_w,
   output logic signed [aavr_pkg::R_W-1:0]      q_x,
   output logic signed [aavr_pkg::R_W-1:0]      q_y,
   output logic signed [aavr_pkg::R_W-1:0]      q_z,
   output logic signed [aavr_pkg::VEC_W-1:0]    v_x,
   output logic signed [aavr_pkg::VEC_W-1:0]    v_y,
   output logic signed [aavr_pkg::VEC_W-1:0]    v_z
);

   localparam int QW = aavr_pkg::QPH_W + aavr_pkg::IDX_W;

   logic [aavr_pkg::PHASE_W-1:0] ph_sin, ph_cos;
   logic [QW-1:0] sc_sin, sc_cos;
   logic [aavr_pkg::IDX_W-1:0] ix_sin, ix_cos;

   logic [aavr_pkg::IDX_W-1:0] addr_sin_ff, addr_sin_in, addr_cos_ff, addr_cos_in;
   logic neg_sin_ff, neg_cos_ff;
   logic signed [aavr_pkg::AXIS_W-1:0] ax1_ff, ay1_ff, az1_ff, ax2_ff, ay2_ff, az2_ff;
   logic signed [aavr_pkg::VEC_W-1:0]  vx1_ff, vy1_ff, vz1_ff, vx2_ff, vy2_ff, vz2_ff;
   logic signed [aavr_pkg::SN_W-1:0]   sn_ff, sn_in, cs_ff, cs_in;
   logic signed [aavr_pkg::R_W-1:0]    w_ff, rx_ff, ry_ff, rz_ff;
   logic signed [aavr_pkg::VEC_W-1:0]  vx3_ff, vy3_ff, vz3_ff;
   logic signed [aavr_pkg::AXIS_W+aavr_pkg::SN_W-1:0] px, py, pz;

   always_comb begin
      ph_sin = aavr_pkg::PHASE_W'(angle[aavr_pkg::ANGLE_BITS-1:0]);
      ph_cos = ph_sin + (aavr_pkg::PHASE_W'(1) << aavr_pkg::QPH_W);
      sc_sin = QW'(ph_sin[aavr_pkg::QPH_W-1:0]) * QW'(aavr_pkg::SINE_TABLE_DEPTH);
      sc_cos = QW'(ph_cos[aavr_pkg::QPH_W-1:0]) * QW'(aavr_pkg::SINE_TABLE_DEPTH);
      ix_sin = aavr_pkg::IDX_W'(sc_sin >> aavr_pkg::QPH_W);
      ix_cos = aavr_pkg::IDX_W'(sc_cos >> aavr_pkg::QPH_W);
      addr_sin_in = ph_sin[aavr_pkg::QPH_W]
                  ? aavr_pkg::IDX_W'(aavr_pkg::SINE_TABLE_DEPTH) - ix_sin : ix_sin;
      addr_cos_in = ph_cos[aavr_pkg::QPH_W]
                  ? aavr_pkg::IDX_W'(aavr_pkg::SINE_TABLE_DEPTH) - ix_cos : ix_cos;
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[aavr_pkg::ST_INDEX]) begin
         addr_sin_ff <= addr_sin_in;
         addr_cos_ff <= addr_cos_in;
         neg_sin_ff  <= ph_sin[aavr_pkg::PHASE_W-1];
         neg_cos_ff  <= ph_cos[aavr_pkg::PHASE_W-1];
         ax1_ff <= axis_x;
         ay1_ff <= axis_y;
         az1_ff <= axis_z;
         vx1_ff <= vec_x;
         vy1_ff <= vec_y;
         vz1_ff <= vec_z;
      end
   end

   always_comb begin
      sn_in = $signed(aavr_pkg::SN_W'(aavr_pkg::SIN_ROM[addr_sin_ff]));
      cs_in = $signed(aavr_pkg::SN_W'(aavr_pkg::SIN_ROM[addr_cos_ff]));
      if (neg_sin_ff) begin
         sn_in = -sn_in;
      end
      if (neg_cos_ff) begin
         cs_in = -cs_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[aavr_pkg::ST_LOOKUP]) begin
         sn_ff  <= sn_in;
         cs_ff  <= cs_in;
         ax2_ff <= ax1_ff;
         ay2_ff <= ay1_ff;
         az2_ff <= az1_ff;
         vx2_ff <= vx1_ff;
         vy2_ff <= vy1_ff;
         vz2_ff <= vz1_ff;
      end
   end

   assign px = ax2_ff * sn_ff;
   assign py = ay2_ff * sn_ff;
   assign pz = az2_ff * sn_ff;

   always_ff @(posedge clock) begin
      if (ctrl.load[aavr_pkg::ST_QUAT]) begin
         w_ff   <= aavr_pkg::R_W'(cs_ff);
         rx_ff  <= aavr_pkg::R_W'(aavr_pkg::rnd_shift(64'(px), aavr_pkg::AXIS_FRAC));
         ry_ff  <= aavr_pkg::R_W'(aavr_pkg::rnd_shift(64'(py), aavr_pkg::AXIS_FRAC));
         rz_ff  <= aavr_pkg::R_W'(aavr_pkg::rnd_shift(64'(pz), aavr_pkg::AXIS_FRAC));
         vx3_ff <= vx2_ff;
         vy3_ff <= vy2_ff;
         vz3_ff <= vz2_ff;
      end
   end

   assign q_w = w_ff;
   assign q_x = rx_ff;
   assign q_y = ry_ff;
   assign q_z = rz_ff;
   assign v_x = vx3_ff;
   assign v_y = vy3_ff;
   assign v_z = vz3_ff;

endmodule

@@ design/aavr_prod1.sv @@
// ----------------------------------------------------------------------------
// aavr_prod1
// First quaternion product t = q * v: partial products, then rounded sums.
// ----------------------------------------------------------------------------
module aavr_prod1 (
   input  logic                              clock,
   input  aavr_pkg::pipe_ctrl_type           ctrl,
   input  logic signed [aavr_pkg::R_W-1:0]   q_w,
   input  logic signed [aavr_pkg::R_W-1:0]   q_x,
   input  logic signed [aavr_pkg::R_W-1:0]   q_y,
   input  logic signed [aavr_pkg::R_W-1:0]   q_z,
   input  logic signed [aavr_pkg::VEC_W-1:0] v_x,
   input  logic signed [aavr_pkg::VEC_W-1:0] v_y,
   input  logic signed [aavr_pkg::VEC_W-1:0] v_z,
   output logic signed [aavr_pkg::T_W-1:0]   t_w,
   output logic signed [aavr_pkg::T_W-1:0]   t_x,
   output logic signed [aavr_pkg::T_W-1:0]   t_y,
   output logic signed [aavr_pkg::T_W-1:0]   t_z,
   output logic signed [aavr_pkg::R_W-1:0]   r_w,
   output logic signed [aavr_pkg::R_W-1:0]   r_x,
   output logic signed [aavr_pkg::R_W-1:0]   r_y,
   output logic signed [aavr_pkg::R_W-1:0]   r_z
);

   logic signed [aavr_pkg::P1_W-1:0] xx_ff, yy_ff, zz_ff;
   logic signed [aavr_pkg::P1_W-1:0] wx_ff, yz_ff, zy_ff;
   logic signed [aavr_pkg::P1_W-1:0] wy_ff, zx_ff, xz_ff;
   logic signed [aavr_pkg::P1_W-1:0] wz_ff, xy_ff, yx_ff;
   logic signed [aavr_pkg::R_W-1:0]  w4_ff, x4_ff, y4_ff, z4_ff;
   logic signed [aavr_pkg::R_W-1:0]  w5_ff, x5_ff, y5_ff, z5_ff;
   logic signed [aavr_pkg::T_W-1:0]  tw_ff, tx_ff, ty_ff, tz_ff;
   logic signed [63:0] sw, sx, sy, sz;

   always_ff @(posedge clock) begin
      if (ctrl.load[aavr_pkg::ST_PROD1]) begin
         xx_ff <= q_x * v_x;
         yy_ff <= q_y * v_y;
         zz_ff <= q_z * v_z;
         wx_ff <= q_w * v_x;
         yz_ff <= q_y * v_z;
         zy_ff <= q_z * v_y;
         wy_ff <= q_w * v_y;
         zx_ff <= q_z * v_x;
         xz_ff <= q_x * v_z;
         wz_ff <= q_w * v_z;
         xy_ff <= q_x * v_y;
         yx_ff <= q_y * v_x;
         w4_ff <= q_w;
         x4_ff <= q_x;
         y4_ff <= q_y;
         z4_ff <= q_z;
      end
   end

   always_comb begin
      sw = -(64'(xx_ff) + 64'(yy_ff) + 64'(zz_ff));
      sx = 64'(wx_ff) + 64'(yz_ff) - 64'(zy_ff);
      sy = 64'(wy_ff) + 64'(zx_ff) - 64'(xz_ff);
      sz = 64'(wz_ff) + 64'(xy_ff) - 64'(yx_ff);
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[aavr_pkg::ST_SUM1]) begin
         tw_ff <= aavr_pkg::T_W'(aavr_pkg::rnd_shift(sw, aavr_pkg::TRIG_FRAC));
         tx_ff <= aavr_pkg::T_W'(aavr_pkg::rnd_shift(sx, aavr_pkg::TRIG_FRAC));
         ty_ff <= aavr_pkg::T_W'(aavr_pkg::rnd_shift(sy, aavr_pkg::TRIG_FRAC));
         tz_ff <= aavr_pkg::T_W'(aavr_pkg::rnd_shift(sz, aavr_pkg::TRIG_FRAC));
         w5_ff <= w4_ff;
         x5_ff <= x4_ff;
         y5_ff <= y4_ff;
         z5_ff <= z4_ff;
      end
   end

   assign t_w = tw_ff;
   assign t_x = tx_ff;
   assign t_y = ty_ff;
   assign t_z = tz_ff;
   assign r_w = w5_ff;
   assign r_x = x5_ff;
   assign r_y = y5_ff;
   assign r_z = z5_ff;

endmodule

@@ design/aavr_prod2.sv @@
// ----------------------------------------------------------------------------
// aavr_prod2
// Second product t * conj(q): partial products, rounded sums, saturation.
// ----------------------------------------------------------------------------
module aavr_prod2 (
   input  logic                              clock,
   input  aavr_pkg::pipe_ctrl_type           ctrl,
   input  logic signed [aavr_pkg::T_W-1:0]   t_w,
   input  logic signed [aavr_pkg::T_W-1:0]   t_x,
   input  logic signed [aavr_pkg::T_W-1:0]   t_y,
   input  logic signed [aavr_pkg::T_W-1:0]   t_z,
   input  logic signed [aavr_pkg::R_W-1:0]   r_w,
   input  logic signed [aavr_pkg::R_W-1:0]   r_x,
   input  logic signed [aavr_pkg::R_W-1:0]   r_y,
   input  logic signed [aavr_pkg::R_W-1:0]   r_z,
   output logic signed [aavr_pkg::VEC_W-1:0] out_x,
   output logic signed [aavr_pkg::VEC_W-1:0] out_y,
   output logic signed [aavr_pkg::VEC_W-1:0] out_z
);

   logic signed [aavr_pkg::P2_W-1:0] wx_ff, xw_ff, yz_ff, zy_ff;
   logic signed [aavr_pkg::P2_W-1:0] wy_ff, xz_ff, yw_ff, zx_ff;
   logic signed [aavr_pkg::P2_W-1:0] wz_ff, xy_ff, yx_ff, zw_ff;
   logic signed [aavr_pkg::VEC_W-1:0] ox_ff, oy_ff, oz_ff;
   logic signed [63:0] sx, sy, sz;

   always_ff @(posedge clock) begin
      if (ctrl.load[aavr_pkg::ST_PROD2]) begin
         wx_ff <= t_w * r_x;
         xw_ff <= t_x * r_w;
         yz_ff <= t_y * r_z;
         zy_ff <= t_z * r_y;
         wy_ff <= t_w * r_y;
         xz_ff <= t_x * r_z;
         yw_ff <= t_y * r_w;
         zx_ff <= t_z * r_x;
         wz_ff <= t_w * r_z;
         xy_ff <= t_x * r_y;
         yx_ff <= t_y * r_x;
         zw_ff <= t_z * r_w;
      end
   end

   always_comb begin
      sx = -64'(wx_ff) + 64'(xw_ff) - 64'(yz_ff) + 64'(zy_ff);
      sy = -64'(wy_ff) + 64'(xz_ff) + 64'(yw_ff) - 64'(zx_ff);
      sz = -64'(wz_ff) - 64'(xy_ff) + 64'(yx_ff) + 64'(zw_ff);
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[aavr_pkg::ST_OUT]) begin
         ox_ff <= aavr_pkg::sat32(aavr_pkg::rnd_shift(sx, aavr_pkg::TRIG_FRAC));
         oy_ff <= aavr_pkg::sat32(aavr_pkg::rnd_shift(sy, aavr_pkg::TRIG_FRAC));
         oz_ff <= aavr_pkg::sat32(aavr_pkg::rnd_shift(sz, aavr_pkg::TRIG_FRAC));
      end
   end

   assign out_x = ox_ff;
   assign out_y = oy_ff;
   assign out_z = oz_ff;

endmodule

@@ design/axis_angle_vector_rotate.sv @@
// A request moves through the index, lookup, quat, prod1, sum1, prod2 and out stages.
// Throughput: one request per cycle, set by the seven-stage pipeline, which
// advances every cycle unless the result side stalls.
// Stalls hold each full stage; an empty stage still takes new data.
// Reset empties every stage; the sine table is constant and needs no fill.
// ----------------------------------------------------------------------------
// axis_angle_vector_rotate
// Rotates a Q16.16 vector about a Q1.14 axis by a binary angle, q * v * q'.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module axis_angle_vector_rotate (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // angle, axis_x, axis_y, axis_z, vec_x, vec_y, vec_z
   input  logic [aavr_pkg::REQ_W-1:0]  req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // out_x, out_y, out_z
   output logic [aavr_pkg::RSP_W-1:0]  rsp_tdata
);

   logic [aavr_pkg::NUM_STAGES-1:0] valid_ff, valid_in;
   logic [aavr_pkg::NUM_STAGES:0]   take;
   aavr_pkg::pipe_ctrl_type         ctrl;

   logic signed [aavr_pkg::R_W-1:0]   q_w, q_x, q_y, q_z, r_w, r_x, r_y, r_z;
   logic signed [aavr_pkg::VEC_W-1:0] v_x, v_y, v_z, out_x, out_y, out_z;
   logic signed [aavr_pkg::T_W-1:0]   t_w, t_x, t_y, t_z;

   always_comb begin
      take[aavr_pkg::NUM_STAGES] = rsp_tready;
      for (int k = aavr_pkg::NUM_STAGES - 1; k >= 0; k--) begin
         take[k] = !valid_ff[k] || take[k+1];
      end
      ctrl.load = take[aavr_pkg::NUM_STAGES-1:0];
      valid_in[0] = take[0] ? req_tvalid : valid_ff[0];
      for (int k = 1; k < aavr_pkg::NUM_STAGES; k++) begin
         if (take[k]) begin
            valid_in[k] = valid_ff[k-1];
         end else begin
            valid_in[k] = valid_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_tready = take[0];
   assign rsp_tvalid = valid_ff[aavr_pkg::NUM_STAGES-1];
   assign rsp_tdata  = {out_z, out_y, out_x};

   aavr_quat u_quat (
      .clock  (clock),
      .ctrl   (ctrl),
      .angle  (req_tdata[15:0]),
      .axis_x ($signed(req_tdata[31:16])),
      .axis_y ($signed(req_tdata[47:32])),
      .axis_z ($signed(req_tdata[63:48])),
      .vec_x  ($signed(req_tdata[95:64])),
      .vec_y  ($signed(req_tdata[127:96])),
      .vec_z  ($signed(req_tdata[159:128])),
      .q_w    (q_w),
      .q_x    (q_x),
      .q_y    (q_y),
      .q_z    (q_z),
      .v_x    (v_x),
      .v_y    (v_y),
      .v_z    (v_z)
   );

   aavr_prod1 u_prod1 (
      .clock (clock),
      .ctrl  (ctrl),
      .q_w   (q_w),
      .q_x   (q_x),
      .q_y   (q_y),
      .q_z   (q_z),
      .v_x   (v_x),
      .v_y   (v_y),
      .v_z   (v_z),
      .t_w   (t_w),
      .t_x   (t_x),
      .t_y   (t_y),
      .t_z   (t_z),
      .r_w   (r_w),
      .r_x   (r_x),
      .r_y   (r_y),
      .r_z   (r_z)
   );

   aavr_prod2 u_prod2 (
      .clock (clock),
      .ctrl  (ctrl),
      .t_w   (t_w),
      .t_x   (t_x),
      .t_y   (t_y),
      .t_z   (t_z),
      .r_w   (r_w),
      .r_x   (r_x),
      .r_y   (r_y),
      .r_z   (r_z),
      .out_x (out_x),
      .out_y (out_y),
      .out_z (out_z)
   );

   `ASSERT_NEXT(a_accept_fills, clock, reset, req_tvalid && req_tready, valid_ff[0],
      "accepted request did not enter the first stage")
   `ASSERT_ALWAYS(a_full_blocks, clock, reset,
      !((&valid_ff) && !rsp_tready && req_tready), "full stalled pipeline took a request")
   `ASSERT_NEXT(a_drain, clock, reset,
      !valid_ff[aavr_pkg::NUM_STAGES-2] && rsp_tvalid && rsp_tready, !rsp_tvalid,
      "result repeated after it was taken")

endmodule

@@ verif/axis_angle_vector_rotate_tb.sv @@
// ----------------------------------------------------------------------------
// axis_angle_vector_rotate_tb
// Self-checking bench for the quaternion vector rotator. Requests are driven
// over the input stream with random gaps. Responses are drawn with random
// stalls. A scoreboard predicts every rotation in fixed point and checks each
// response field by field, in order.
// ----------------------------------------------------------------------------
module axis_angle_vector_rotate_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } rot_vec_type;

   class rotation_scoreboard;
      longint rom [0:1024];
      rot_vec_type rotated_q[$];
      int errors;

      function new();
         longint unsigned th, t2, term, v;
         longint sum;
         for (int k = 0; k < 1024; k++) begin
            th = (64'd1686629713 * 64'(k)) / 1024;
            t2 = (th * th) >> 30;
            term = th;
            sum = longint'(th);
            for (int n = 1; n <= 11; n++) begin
               term = (term * t2) >> 30;
               term = term / ((2 * n) * (2 * n + 1));
               if (n % 2 == 1) begin
                  sum = sum - longint'(term);
               end else begin
                  sum = sum + longint'(term);
               end
            end
            if (sum < 0) begin
               sum = 0;
            end
            v = (longint'(sum) + 32) >> 6;
            if (v > (64'd1 << 24)) begin
               v = 64'd1 << 24;
            end
            rom[k] = longint'(v);
         end
         rom[1024] = 64'sd1 << 24;
         errors = 0;
      endfunction

      function longint round_shift(longint v, int s);
         longint unsigned mag, r;
         mag = (v < 0) ? longint'(-v) : longint'(v);
         r = (mag + (64'd1 << (s - 1))) >> s;
         return (v < 0) ? -longint'(r) : longint'(r);
      endfunction

      function longint sine_q24(logic [16:0] p);
         logic [1:0] quad;
         int idx;
         longint val;
         quad = p[16:15];
         idx = (int'(p[14:0]) * 1024) >> 15;
         val = quad[0] ? rom[1024 - idx] : rom[idx];
         return quad[1] ? -val : val;
      endfunction

      function logic signed [31:0] clamp(longint v);
         if (v > 64'sd2147483647) begin
            return 32'sh7fffffff;
         end else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
         end
         return v[31:0];
      endfunction

      function void note_request(logic [159:0] d);
         longint sn, w, rx, ry, rz, vx, vy, vz, tw, tx, ty, tz;
         logic [16:0] a;
         rot_vec_type r;
         a = {1'b0, d[15:0]};
         sn = sine_q24(a);
         w = sine_q24(a + 17'h08000);
         rx = round_shift(longint'($signed(d[31:16])) * sn, 14);
         ry = round_shift(longint'($signed(d[47:32])) * sn, 14);
         rz = round_shift(longint'($signed(d[63:48])) * sn, 14);
         vx = longint'($signed(d[95:64]));
         vy = longint'($signed(d[127:96]));
         vz = longint'($signed(d[159:128]));
         tw = round_shift(-(rx * vx + ry * vy + rz * vz), 24);
         tx = round_shift(w * vx + ry * vz - rz * vy, 24);
         ty = round_shift(w * vy + rz * vx - rx * vz, 24);
         tz = round_shift(w * vz + rx * vy - ry * vx, 24);
         r.x = clamp(round_shift(-tw * rx + tx * w - ty * rz + tz * ry, 24));
         r.y = clamp(round_shift(-tw * ry + tx * rz + ty * w - tz * rx, 24));
         r.z = clamp(round_shift(-tw * rz - tx * ry + ty * rx + tz * w, 24));
         rotated_q.push_back(r);
      endfunction

      function void check_response(logic [95:0] d);
         rot_vec_type e;
         if (rotated_q.size() == 0) begin
            $error("unexpected response %h", d);
            errors++;
            return;
         end
         e = rotated_q.pop_front();
         if (d[31:0] !== e.x) begin
            $error("out_x expected %h actual %h", e.x, d[31:0]);
            errors++;
         end
         if (d[63:32] !== e.y) begin
            $error("out_y expected %h actual %h", e.y, d[63:32]);
            errors++;
         end
         if (d[95:64] !== e.z) begin
            $error("out_z expected %h actual %h", e.z, d[95:64]);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [159:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;

   rotation_scoreboard sb = new();
   bit calm = 1'b0;
   bit long_hold = 1'b0;
   int cycles = 0;

   axis_angle_vector_rotate i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 300000) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // response side: random stalls, one long hold on request
   int stall_left = 0;
   int run_left = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            sb.check_response(rsp_tdata);
         end
         if (long_hold) begin
            long_hold <= 1'b0;
            stall_left <= 400;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_tready <= 1'b0;
         end else if (!calm && run_left == 0) begin
            run_left <= $urandom_range(1, 30);
            if ($urandom_range(0, 1)) begin
               stall_left <= $urandom_range(1, 18);
               rsp_tready <= 1'b0;
            end else begin
               rsp_tready <= 1'b1;
            end
         end else begin
            if (run_left > 0) begin
               run_left <= run_left - 1;
            end
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic send(logic [159:0] d);
      req_tvalid <= 1'b1;
      req_tdata <= d;
      do @(posedge clock); while (!req_tready);
      sb.note_request(d);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
   endtask

   function automatic logic [159:0] pack(logic [15:0] a, logic [15:0] ax, logic [15:0] ay,
                                         logic [15:0] az, logic [31:0] vx, logic [31:0] vy,
                                         logic [31:0] vz);
      return {vz, vy, vx, az, ay, ax, a};
   endfunction

   function automatic logic [15:0] axis_part();
      case ($urandom_range(0, 3))
         0: return 16'sd0;
         1: return 16'sd16384;
         2: return -16'sd16384;
         default: return 16'($urandom_range(0, 32767) - 16384);
      endcase
   endfunction

   function automatic logic [31:0] vec_part();
      if ($urandom_range(0, 3) == 0) begin
         return $urandom();
      end
      return 32'($signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000);
   endfunction

   initial begin
      logic [15:0] ang [5] = '{16'h0000, 16'h4000, 16'h8000, 16'hc000, 16'hffff};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (ang[i]) begin
         send(pack(ang[i], 16'sd16384, 16'd0, 16'd0, 32'h00010000, 32'h00020000,
                   32'h00030000));
         send(pack(ang[i], 16'd0, 16'd0, 16'sd16384, 32'h7fffffff, 32'h80000000,
                   32'h00000001));
      end
      send(pack(16'h4000, 16'h7fff, 16'h7fff, 16'h7fff, 32'h7fffffff, 32'h7fffffff,
                32'h7fffffff));
      send(pack(16'h2000, 16'h8000, 16'h8000, 16'h8000, 32'h80000000, 32'h80000000,
                32'h80000000));
      send(pack(16'h1234, 16'h8000, 16'h7fff, 16'h0000, 32'h80000000, 32'h7fffffff,
                32'd0));
      send(pack(16'h5555, 16'd0, 16'd0, 16'd0, 32'h12345678, 32'h9abcdef0, 32'h0f0f0f0f));
      send(pack(16'haaaa, 16'sd9459, 16'sd9459, 16'sd9459, 32'd0, 32'd0, 32'd0));
      send(pack(16'h3fff, 16'sd11585, -16'sd11585, 16'd0, 32'hffffffff, 32'h00000000,
                32'h00010000));
      long_hold <= 1'b1;
      for (int i = 0; i < 900; i++) begin
         if (i == 450) begin
            req_tvalid <= 1'b0;
            while (sb.rotated_q.size() != 0) @(posedge clock);
         end
         if (i == 750) begin
            calm <= 1'b1;
         end
         if ($urandom_range(0, 2) == 0) begin
            send(pack(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()),
                      $urandom(), $urandom(), $urandom()));
         end else begin
            send(pack(16'($urandom()), axis_part(), axis_part(), axis_part(),
                      vec_part(), vec_part(), vec_part()));
         end
      end
      req_tvalid <= 1'b0;
      while (sb.rotated_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end
endmodule

@@ sim.f @@
+incdir+design
design/aavr_pkg.sv
design/aavr_quat.sv
design/aavr_prod1.sv
design/aavr_prod2.sv
design/axis_angle_vector_rotate.sv
verif/axis_angle_vector_rotate_tb.sv
